FILE: hdl/ipid_pkg.sv
// Shared constants, microcode types and the microcode table of the PID position loop.
package ipid_pkg;

  // Default field widths.
  localparam int POSITION_BITS = 24;
  localparam int GAIN_BITS     = 16;

  // Fixed register and output widths.
  localparam int MAXI_W = 31;
  localparam int MAXC_W = 16;
  localparam int CTRL_W = 17;

  // Configuration port geometry.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int REGI_W = 3;

  // Register indexes.
  localparam logic [REGI_W-1:0] REG_KP_NUM       = 3'd0;
  localparam logic [REGI_W-1:0] REG_KI_NUM       = 3'd1;
  localparam logic [REGI_W-1:0] REG_KD_NUM       = 3'd2;
  localparam logic [REGI_W-1:0] REG_GAIN_DEN     = 3'd3;
  localparam logic [REGI_W-1:0] REG_MAX_INTEGRAL = 3'd4;
  localparam logic [REGI_W-1:0] REG_MAX_CONTROL  = 3'd5;

  // Microprogram step addresses.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LOAD     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INTEG    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_I    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_P    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_D    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ACC_D    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIV      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUT      = 4'd8;

  // Datapath operation of a step.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INTEG,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUTPUT
  } ipid_op_e;

  // Multiplier operand pair of a step.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_I,
    MUL_P,
    MUL_D
  } ipid_mul_e;

  // Accumulator action of a step.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } ipid_acc_e;

  // Sequencing of a step: advance, wait for an item, loop on the count, wait for the output.
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_IN,
    COND_CNT,
    COND_OUT
  } ipid_cond_e;

  typedef struct packed {
    ipid_op_e          op;
    ipid_mul_e         mul;
    ipid_acc_e         acc;
    ipid_cond_e        cond;
    logic [STEP_W-1:0] target;
  } ipid_cw_t;

  // The microprogram.
  function automatic ipid_cw_t ipid_ucode(input logic [STEP_W-1:0] step);
    ipid_cw_t cw;
    cw = '{op: OP_NOP, mul: MUL_NONE, acc: ACC_HOLD, cond: COND_NEXT, target: STEP_LOAD};
    case (step)
      STEP_LOAD:     cw = '{OP_LOAD,     MUL_NONE, ACC_HOLD, COND_IN,   STEP_LOAD};
      STEP_INTEG:    cw = '{OP_INTEG,    MUL_NONE, ACC_HOLD, COND_NEXT, STEP_LOAD};
      STEP_MUL_I:    cw = '{OP_NOP,      MUL_I,    ACC_HOLD, COND_NEXT, STEP_LOAD};
      STEP_MUL_P:    cw = '{OP_NOP,      MUL_P,    ACC_LOAD, COND_NEXT, STEP_LOAD};
      STEP_MUL_D:    cw = '{OP_NOP,      MUL_D,    ACC_ADD,  COND_NEXT, STEP_LOAD};
      STEP_ACC_D:    cw = '{OP_NOP,      MUL_NONE, ACC_ADD,  COND_NEXT, STEP_LOAD};
      STEP_DIV_INIT: cw = '{OP_DIV_INIT, MUL_NONE, ACC_HOLD, COND_NEXT, STEP_LOAD};
      STEP_DIV:      cw = '{OP_DIV_STEP, MUL_NONE, ACC_HOLD, COND_CNT,  STEP_DIV};
      STEP_OUT:      cw = '{OP_OUTPUT,   MUL_NONE, ACC_HOLD, COND_OUT,  STEP_LOAD};
      default:       cw = '{OP_NOP,      MUL_NONE, ACC_HOLD, COND_OUT,  STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

FILE: hdl/ipid_in_if.sv
// Input channel carrying target and measured positions.
interface ipid_in_if #(
  parameter int POS_W = ipid_pkg::POSITION_BITS
);
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] setpoint_pos;
  logic [POS_W-1:0] encoder_pos;

  modport source (output valid, output setpoint_pos, output encoder_pos, input ready);
  modport sink   (input valid, input setpoint_pos, input encoder_pos, output ready);
endinterface

FILE: hdl/ipid_out_if.sv
// Output channel carrying the clamped drive value.
interface ipid_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ipid_pkg::CTRL_W-1:0] control_value;

  modport source (output valid, output control_value, input ready);
  modport sink   (input valid, input control_value, output ready);
endinterface

FILE: hdl/integer_pid_position_loop.sv
// Integer PID position loop: a microcoded sequencer over one multiplier and a serial divider.
// An item is accepted at the end of the load step, which captures it, and then moves in order
// through the integral update, three passes through the shared multiplier, the last accumulate,
// divider setup, the restoring divider, which produces one quotient bit per cycle over the full
// sum width, and the output clamp, from which its result enters the output register. The load
// step follows at once, so a new item is taken only after the last one has left the output step.
// The output step waits while an earlier result still sits unread in the output register. That
// register parts the two sides, so a new item is taken while a result still waits to be read.
// Configuration registers sit at byte address 4*i and are to be written only while the loop is
// idle; the user must keep to this, as the block itself does not enforce it.
module integer_pid_position_loop #(
  parameter int POSITION_BITS = ipid_pkg::POSITION_BITS,
  parameter int GAIN_BITS     = ipid_pkg::GAIN_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ipid_in_if.sink                       in_if,
  ipid_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipid_pkg::ADDR_W-1:0]   paddr,
  input  logic [ipid_pkg::DATA_W-1:0]   pwdata,
  output logic [ipid_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ipid_pkg::*;

  localparam int OPA_W  = (POSITION_BITS + 1 > 32) ? POSITION_BITS + 1 : 32;
  localparam int PROD_W = OPA_W + GAIN_BITS;
  localparam int ACC_W  = PROD_W + 1;
  localparam int REM_W  = GAIN_BITS + 1;
  localparam int CNT_W  = $clog2(ACC_W);

  // Configuration registers.
  logic signed [GAIN_BITS-1:0] kp_q, ki_q, kd_q;
  logic        [GAIN_BITS-1:0] den_cfg_q;
  logic        [MAXI_W-1:0]    max_int_q;
  logic        [MAXC_W-1:0]    max_ctl_q;

  // Sequencer.
  logic [STEP_W-1:0] step_q, step_d;
  ipid_cw_t          cw;

  // Datapath.
  logic        [POSITION_BITS-1:0] last_pos_q, last_pos_d;
  logic signed [POSITION_BITS:0]   err_q, err_d, delta_q, delta_d;
  logic signed [31:0]              integral_q, integral_d;
  logic signed [PROD_W-1:0]        prod_q, prod_d;
  logic signed [ACC_W-1:0]         acc_q, acc_d;
  logic        [REM_W-1:0]         rem_q, rem_d;
  logic        [GAIN_BITS-1:0]     den_q, den_d;
  logic        [CNT_W-1:0]         cnt_q, cnt_d;
  logic                            neg_q, neg_d;
  logic                            out_valid_q, out_valid_d;
  logic signed [CTRL_W-1:0]        out_value_q, out_value_d;

  logic                            in_accept, out_free, cfg_write;
  logic signed [OPA_W:0]           isum, ilim;
  logic signed [OPA_W-1:0]         mul_a;
  logic signed [GAIN_BITS-1:0]     mul_b;
  logic        [REM_W-1:0]         trial;
  logic                            ge;
  logic        [MAXC_W-1:0]        mag_clamped;
  logic        [CTRL_W-1:0]        mag_ext;
  logic        [CTRL_W-1:0]        out_mag;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      den_cfg_q <= GAIN_BITS'(1);
      max_int_q <= '1;
      max_ctl_q <= '1;
    end else if (cfg_write) begin
      case (paddr[ADDR_W-1:2])
        REG_KP_NUM:       kp_q      <= pwdata[GAIN_BITS-1:0];
        REG_KI_NUM:       ki_q      <= pwdata[GAIN_BITS-1:0];
        REG_KD_NUM:       kd_q      <= pwdata[GAIN_BITS-1:0];
        REG_GAIN_DEN:     den_cfg_q <= pwdata[GAIN_BITS-1:0];
        REG_MAX_INTEGRAL: max_int_q <= pwdata[MAXI_W-1:0];
        REG_MAX_CONTROL:  max_ctl_q <= pwdata[MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_KP_NUM:       prdata = DATA_W'(unsigned'(kp_q));
      REG_KI_NUM:       prdata = DATA_W'(unsigned'(ki_q));
      REG_KD_NUM:       prdata = DATA_W'(unsigned'(kd_q));
      REG_GAIN_DEN:     prdata = DATA_W'(den_cfg_q);
      REG_MAX_INTEGRAL: prdata = DATA_W'(max_int_q);
      REG_MAX_CONTROL:  prdata = DATA_W'(max_ctl_q);
      default:          prdata = '0;
    endcase
  end

  // Control word fetch and handshakes.
  assign cw           = ipid_ucode(step_q);
  assign in_if.ready  = (cw.op == OP_LOAD);
  assign in_accept    = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_q || out_if.ready;
  assign out_if.valid = out_valid_q;
  assign out_if.control_value = out_value_q;

  // Next step address.
  always_comb begin
    step_d = step_q;
    case (cw.cond)
      COND_NEXT: step_d = step_q + STEP_W'(1);
      COND_IN:   if (in_accept) step_d = step_q + STEP_W'(1);
      COND_CNT:  step_d = (cnt_q != '0) ? cw.target : step_q + STEP_W'(1);
      COND_OUT:  if (out_free) step_d = cw.target;
      default:   step_d = STEP_LOAD;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (cw.mul)
      MUL_I:   begin mul_a = OPA_W'(integral_q); mul_b = ki_q; end
      MUL_P:   begin mul_a = OPA_W'(err_q);      mul_b = kp_q; end
      MUL_D:   begin mul_a = OPA_W'(delta_q);    mul_b = kd_q; end
      default: begin mul_a = OPA_W'(integral_q); mul_b = ki_q; end
    endcase
    prod_d = (cw.mul == MUL_NONE) ? prod_q : mul_a * mul_b;
  end

  // Integral update with symmetric clamp.
  assign isum = (OPA_W + 1)'(integral_q) + (OPA_W + 1)'(err_q);
  assign ilim = (OPA_W + 1)'(max_int_q);

  // One restoring divide step on the magnitude.
  assign trial = {rem_q[REM_W-2:0], acc_q[ACC_W-1]};
  assign ge    = (trial >= REM_W'(den_q));

  // Output clamp on the quotient magnitude.
  assign mag_clamped = (unsigned'(acc_q) > ACC_W'(max_ctl_q)) ? max_ctl_q : acc_q[MAXC_W-1:0];
  assign mag_ext     = CTRL_W'(mag_clamped);

  // Datapath operations.
  always_comb begin
    last_pos_d  = last_pos_q;
    err_d       = err_q;
    delta_d     = delta_q;
    integral_d  = integral_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    out_value_d = out_value_q;
    out_valid_d = out_valid_q && !out_if.ready;

    case (cw.op)
      OP_LOAD: begin
        if (in_accept) begin
          err_d      = signed'({1'b0, in_if.encoder_pos}) - signed'({1'b0, in_if.setpoint_pos});
          delta_d    = signed'({1'b0, in_if.encoder_pos}) - signed'({1'b0, last_pos_q});
          last_pos_d = in_if.encoder_pos;
        end
      end
      OP_INTEG: begin
        if (isum > ilim) begin
          integral_d = 32'(ilim);
        end else if (isum < -ilim) begin
          integral_d = 32'(-ilim);
        end else begin
          integral_d = 32'(isum);
        end
      end
      OP_DIV_INIT: begin
        neg_d = acc_q[ACC_W-1];
        acc_d = acc_q[ACC_W-1] ? -acc_q : acc_q;
        rem_d = '0;
        den_d = (den_cfg_q == '0) ? GAIN_BITS'(1) : den_cfg_q;
        cnt_d = CNT_W'(ACC_W - 1);
      end
      OP_DIV_STEP: begin
        rem_d = ge ? trial - REM_W'(den_q) : trial;
        acc_d = {acc_q[ACC_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
      end
      OP_OUTPUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = neg_q ? -signed'(mag_ext) : signed'(mag_ext);
        end
      end
      default: ;
    endcase

    // Accumulation of the product terms.
    case (cw.acc)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      default:  ;
    endcase
  end

  // Control and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_LOAD;
      out_valid_q <= 1'b0;
      last_pos_q  <= '0;
      integral_q  <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      last_pos_q  <= last_pos_d;
      integral_q  <= integral_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    delta_q     <= delta_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    den_q       <= den_d;
    cnt_q       <= cnt_d;
    neg_q       <= neg_d;
    out_value_q <= out_value_d;
  end

  assign out_mag = out_value_q[CTRL_W-1] ? -out_value_q : out_value_q;

  // An accepted item always moves on to the integral update.
  a_accept_to_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> step_q == STEP_INTEG)
    else $error("accepted item did not advance to the integral update");

  // The stored integral stays inside its clamp once updated.
  a_integral_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_MUL_I |-> (integral_q <= signed'({1'b0, max_int_q}))
                          && (integral_q >= -signed'({1'b0, max_int_q})))
    else $error("integral outside its clamp");

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_DIV |-> rem_q < REM_W'(den_q))
    else $error("divider remainder not below divisor");

  // A result appears only from the output step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q == STEP_OUT))
    else $error("result appeared outside the output step");

  // A delivered drive value respects the drive clamp.
  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_mag <= CTRL_W'(max_ctl_q))
    else $error("drive value outside its clamp");

endmodule

FILE: hdl/integral_pid_placeholder.sv
// Intentionally minimal: holds nothing used by the design.

FILE: bench/tb_top.sv
// Self-checking testbench for the integer PID position loop with a drive-value predictor.
module tb_top;
  import ipid_pkg::*;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [REGI_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [REGI_W-1:0] REG_NONE_HI = 3'd7;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 80;

  // Predicts the drive value of each position item and holds the values still due.
  class drive_calc;
    logic signed [GAIN_BITS-1:0] kp;
    logic signed [GAIN_BITS-1:0] ki;
    logic signed [GAIN_BITS-1:0] kd;
    logic [GAIN_BITS-1:0]        den;
    logic [MAXI_W-1:0]           int_limit;
    logic [MAXC_W-1:0]           drive_limit;
    logic [POSITION_BITS-1:0]    last_meas;
    longint                      integral;
    logic signed [CTRL_W-1:0]    drives_due[$];
    int                          mismatches;
    int                          checked;

    function new();
      kp          = '0;
      ki          = '0;
      kd          = '0;
      den         = GAIN_BITS'(1);
      int_limit   = '1;
      drive_limit = '1;
      last_meas   = '0;
      integral    = 0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH: %s", msg);
    endtask

    function int pending();
      return drives_due.size();
    endfunction

    // Register writes keep only the bits that the register holds.
    function void load_register(logic [REGI_W-1:0] idx, logic [DATA_W-1:0] word);
      case (idx)
        REG_KP_NUM:       kp = word[GAIN_BITS-1:0];
        REG_KI_NUM:       ki = word[GAIN_BITS-1:0];
        REG_KD_NUM:       kd = word[GAIN_BITS-1:0];
        REG_GAIN_DEN:     den = word[GAIN_BITS-1:0];
        REG_MAX_INTEGRAL: int_limit = word[MAXI_W-1:0];
        REG_MAX_CONTROL:  drive_limit = word[MAXC_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // One control step: update the integral, sum the terms, divide and clamp.
    function void take_positions(logic [POSITION_BITS-1:0] tgt,
                                 logic [POSITION_BITS-1:0] meas);
      longint err;
      longint chg;
      longint total;
      longint divisor;
      longint drive;
      err       = longint'(meas) - longint'(tgt);
      chg       = longint'(meas) - longint'(last_meas);
      last_meas = meas;
      integral  = clip(integral + err, longint'(int_limit));
      total     = integral * longint'(ki) + err * longint'(kp) + chg * longint'(kd);
      divisor   = (den == '0) ? 64'sd1 : longint'(den);
      drive     = clip(total / divisor, longint'(drive_limit));
      drives_due.push_back(CTRL_W'(drive));
    endfunction

    task check_drive(input logic signed [CTRL_W-1:0] got);
      logic signed [CTRL_W-1:0] want;
      checked++;
      if (drives_due.size() == 0) begin
        report($sformatf("drive %0d arrived with nothing expected", got));
      end else begin
        want = drives_due.pop_front();
        if (got !== want)
          report($sformatf("drive %0d, expected %0d (result %0d)", got, want, checked));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  int                   in_idle_pct = 38;
  int                   out_idle_pct = 51;
  int                   items_sent = 0;
  int                   writes_done = 0;
  int                   cycle_count = 0;
  logic [POSITION_BITS-1:0] aim = '0;
  logic [POSITION_BITS-1:0] pos = '0;
  drive_calc            sb = new();

  ipid_in_if  in_ch ();
  ipid_out_if out_ch ();

  integer_pid_position_loop u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock and known start values on every input.
  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.setpoint_pos  = '0;
    in_ch.encoder_pos   = '0;
    out_ch.ready        = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random backpressure on the result side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_drive(out_ch.control_value);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d drives outstanding.", sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Register write: setup cycle, access cycle, then the bus returns to idle.
  task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [DATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.load_register(idx, word);
    writes_done++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one position item; valid is lowered only while the sender idles.
  task automatic send_positions(input logic [POSITION_BITS-1:0] tgt,
                                input logic [POSITION_BITS-1:0] meas);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.setpoint_pos <= tgt;
    in_ch.encoder_pos  <= meas;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.take_positions(tgt, meas);
    items_sent++;
  endtask

  // Stop offering items and wait for every predicted drive to arrive.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_BITS-1:0] random_gain();
    logic signed [GAIN_BITS-1:0] g;
    g = GAIN_BITS'($urandom);
    return g >>> $urandom_range(0, GAIN_BITS - 1);
  endfunction

  // New random setting of all registers, with junk in the unused upper bits.
  task automatic shuffle_config();
    logic [DATA_W-1:0] word;
    int                pick;
    word = $urandom;
    word[GAIN_BITS-1:0] = random_gain();
    write_reg(REG_KP_NUM, word);
    word = $urandom;
    word[GAIN_BITS-1:0] = random_gain();
    write_reg(REG_KI_NUM, word);
    word = $urandom;
    word[GAIN_BITS-1:0] = random_gain();
    write_reg(REG_KD_NUM, word);

    word = $urandom;
    pick = $urandom_range(0, 7);
    if (pick == 0) word[GAIN_BITS-1:0] = '0;
    else if (pick == 1) word[GAIN_BITS-1:0] = '1;
    else if (pick > 3) word[GAIN_BITS-1:0] = GAIN_BITS'($urandom_range(1, 300));
    write_reg(REG_GAIN_DEN, word);

    word = $urandom;
    pick = $urandom_range(0, 5);
    if (pick == 0) word[MAXI_W-1:0] = '0;
    else if (pick == 1) word = '1;
    else if (pick > 2) word[MAXI_W-1:0] = MAXI_W'($urandom_range(0, 100000));
    write_reg(REG_MAX_INTEGRAL, word);

    word = $urandom;
    pick = $urandom_range(0, 5);
    if (pick == 0) word[MAXC_W-1:0] = '0;
    else if (pick == 1) word[MAXC_W-1:0] = '1;
    else if (pick > 3) word[MAXC_W-1:0] = MAXC_W'($urandom_range(0, 2000));
    write_reg(REG_MAX_CONTROL, word);

    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_NONE_LO : REG_NONE_HI, $urandom);
  endtask

  // Mostly a slowly moving position around a stepped target, some wild values and extremes.
  task automatic next_positions(output logic [POSITION_BITS-1:0] tgt,
                                output logic [POSITION_BITS-1:0] meas);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      aim = POSITION_BITS'($urandom);
      pos = POSITION_BITS'($urandom);
    end else if (pick == 2) begin
      aim = $urandom_range(0, 1) ? '1 : '0;
      pos = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      if (pick == 3) aim = pos + POSITION_BITS'($urandom_range(0, 4000)) - POSITION_BITS'(2000);
      pos = pos + POSITION_BITS'($urandom_range(0, 600)) - POSITION_BITS'(300);
    end
    tgt  = aim;
    meas = pos;
  endtask

  // Main sequence.
  initial begin
    logic [POSITION_BITS-1:0] tgt;
    logic [POSITION_BITS-1:0] meas;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small gains and a tight integral clamp; the first step sees a change from zero.
    write_reg(REG_KP_NUM, 32'd3);
    write_reg(REG_KI_NUM, 32'hFFFF_FFFE);
    write_reg(REG_KD_NUM, 32'd5);
    write_reg(REG_GAIN_DEN, 32'd7);
    write_reg(REG_MAX_INTEGRAL, 32'd1000);
    write_reg(REG_MAX_CONTROL, 32'h0000_FFFF);
    write_reg(REG_NONE_LO, 32'hFFFF_FFFF);
    write_reg(REG_NONE_HI, 32'h1234_5678);
    send_positions('0, '1);
    send_positions('1, '0);
    send_positions('1, '1);
    send_positions('0, '0);
    send_positions(24'h123456, 24'h123400);
    // Integral pinned at the positive and then the negative limit.
    repeat (3) send_positions('0, 24'd5000);
    repeat (3) send_positions(24'd5000, '0);
    settle();

    // Extreme gains with junk upper bits, zero divisor and a zero drive clamp.
    write_reg(REG_KP_NUM, 32'hABCD_7FFF);
    write_reg(REG_KI_NUM, 32'h0001_8000);
    write_reg(REG_KD_NUM, 32'hFFFF_7FFF);
    write_reg(REG_GAIN_DEN, 32'hFFFF_0000);
    write_reg(REG_MAX_INTEGRAL, 32'hFFFF_FFFF);
    write_reg(REG_MAX_CONTROL, 32'hFFFF_0000);
    send_positions('0, '1);
    send_positions('0, '1);
    send_positions(24'h800000, 24'h7FFFFF);
    settle();

    // A large integral meets a lowered limit on the very next step; full drive range.
    write_reg(REG_GAIN_DEN, 32'h0000_FFFF);
    write_reg(REG_MAX_CONTROL, 32'hFFFF_FFFF);
    write_reg(REG_MAX_INTEGRAL, 32'd5);
    send_positions(24'h000010, 24'h000020);
    send_positions('1, '0);
    settle();

    // A zero integral limit holds the integral at zero.
    write_reg(REG_MAX_INTEGRAL, 32'h8000_0000);
    write_reg(REG_GAIN_DEN, 32'd1);
    send_positions(24'd1, 24'd2);
    send_positions('1, '1);
    settle();

    // Random part in three pacing phases, with a new setting every forty items.
    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 4) begin
        in_idle_pct  = 51;
        out_idle_pct = 38;
      end else if (seg == 7) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      shuffle_config();
      for (int k = 0; k < 40; k++) begin
        next_positions(tgt, meas);
        send_positions(tgt, meas);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d drives never arrived", sb.pending()));

    $display("Sent %0d position items, checked %0d drive values, made %0d register writes.",
             items_sent, sb.checked, writes_done);
    $display("Pacing ran sender-heavy, receiver-heavy and gap-free; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
